/* rtl/ikg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ikg_pkg: shared types and constants of the interval key grouper
// Table size, field widths, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package ikg_pkg;

	localparam int MaxGroups = 64;
	localparam int IdxW      = $clog2(MaxGroups);
	localparam int CntW      = $clog2(MaxGroups + 1);
	localparam int KeyW      = 20;
	localparam int TimeW     = 32;
	localparam int EntryW    = KeyW + 2 * TimeW;
	localparam int OutIdxW   = 6;
	localparam int OutCntW   = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ikg_state_t;

	typedef struct packed {
		logic load;
		logic scan_en;
		logic commit;
	} ikg_cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_done;
		logic slot_free;
	} ikg_sts_t;

endpackage
`default_nettype wire

/* rtl/ikg_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ikg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ikg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/ikg_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ikg_ctrl: sequencing controller
// Takes a record, runs the table scan and commits the result.
// ----------------------------------------------------------------------------
module ikg_ctrl
	import ikg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire ikg_sts_t sts,
	output ikg_cmd_t      cmd
);

	ikg_state_t state_q;
	ikg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.hit || sts.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/ikg_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ikg_dp: grouping datapath
// Record registers, group table, scan counter, overlap compare, entry
// update and the result register.
// ----------------------------------------------------------------------------
module ikg_dp
	import ikg_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ikg_cmd_t            cmd,
	output ikg_sts_t                 sts,
	input  wire logic                has_image,
	input  wire logic [7:0]          filter_code,
	input  wire logic [7:0]          detector_code,
	input  wire logic [3:0]          frame_type,
	input  wire logic [TimeW-1:0]    time_begin,
	input  wire logic [TimeW-1:0]    time_end,
	input  wire logic                last_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [OutIdxW-1:0]       group_index,
	output logic                     new_group,
	output logic                     skipped,
	output logic                     table_overflow,
	output logic [OutCntW-1:0]       groups_used,
	output logic                     batch_end
);

	logic              img_q;
	logic [KeyW-1:0]   key_q;
	logic [TimeW-1:0]  tb_q;
	logic [TimeW-1:0]  te_q;
	logic              last_q;

	logic [CntW-1:0]   total_q;
	logic [CntW-1:0]   rd_idx_q;
	logic              cmp_vld_s1;
	logic [IdxW-1:0]   cmp_idx_s1;

	logic              hit_q;
	logic [IdxW-1:0]   hit_idx_q;
	logic [TimeW-1:0]  hit_begin_q;
	logic [TimeW-1:0]  hit_finish_q;

	logic              out_valid_q;

	logic              more;
	logic              rd_en;
	logic [EntryW-1:0] rd_data;
	logic [KeyW-1:0]   ent_key;
	logic [TimeW-1:0]  ent_begin;
	logic [TimeW-1:0]  ent_finish;
	logic              hit_now;
	logic [TimeW-1:0]  nar_begin;
	logic [TimeW-1:0]  nar_finish;

	logic              full;
	logic              append;
	logic              ovf;
	logic              wr_en;
	logic [IdxW-1:0]   wr_addr;
	logic [EntryW-1:0] wr_data;
	logic [CntW-1:0]   total_new;
	logic [IdxW-1:0]   res_idx;

	assign more    = rd_idx_q < total_q;
	assign rd_en   = cmd.scan_en && img_q && more;

	assign ent_key    = rd_data[EntryW-1 -: KeyW];
	assign ent_begin  = rd_data[2*TimeW-1 -: TimeW];
	assign ent_finish = rd_data[TimeW-1:0];

	assign hit_now    = img_q && cmp_vld_s1 && (ent_key == key_q) &&
	                    (ent_begin <= te_q) && (ent_finish >= tb_q);
	assign nar_begin  = (tb_q > ent_begin) ? tb_q : ent_begin;
	assign nar_finish = (te_q < ent_finish) ? te_q : ent_finish;

	assign sts.hit       = hit_now;
	assign sts.scan_done = !img_q || (!cmp_vld_s1 && !more);
	assign sts.slot_free = !out_valid_q || out_ready;

	assign full      = total_q == CntW'(MaxGroups);
	assign append    = img_q && !hit_q && !full;
	assign ovf       = img_q && !hit_q && full;
	assign wr_en     = cmd.commit && (append || (img_q && hit_q));
	assign wr_addr   = hit_q ? hit_idx_q : total_q[IdxW-1:0];
	assign wr_data   = hit_q ? {key_q, hit_begin_q, hit_finish_q} : {key_q, tb_q, te_q};
	assign total_new = total_q + CntW'(append);
	assign res_idx   = hit_q ? hit_idx_q : (append ? total_q[IdxW-1:0] : '0);

	ikg_ram #(
		.WIDTH (EntryW),
		.DEPTH (MaxGroups)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_idx_q[IdxW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			img_q  <= has_image;
			key_q  <= {filter_code, detector_code, frame_type};
			tb_q   <= time_begin;
			te_q   <= time_end;
			last_q <= last_item;
		end
		if (rd_en) begin
			cmp_idx_s1 <= rd_idx_q[IdxW-1:0];
		end
		if (cmd.scan_en && hit_now) begin
			hit_idx_q    <= cmp_idx_s1;
			hit_begin_q  <= nar_begin;
			hit_finish_q <= nar_finish;
		end
		if (cmd.commit) begin
			group_index    <= OutIdxW'(res_idx);
			new_group      <= append;
			skipped        <= !img_q;
			table_overflow <= ovf;
			groups_used    <= OutCntW'(total_new);
			batch_end      <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (cmd.load) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CntW'(1);
			end
			if (cmd.scan_en && hit_now) begin
				hit_q <= 1'b1;
			end
			if (cmd.commit) begin
				total_q <= last_q ? '0 : total_new;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/interval_key_grouper.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// interval_key_grouper: groups image records by codes and overlapping time
// Finds the first table entry with equal codes and an overlapping interval,
// narrows it to the intersection, or appends a new entry if the table has room.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | has_image, codes, time_begin/end, last
//   out     | out_valid / out_ready| group_index, flags, groups_used, batch_end
//
// On a miss the scan covers every entry held, on a hit it ends at the hit
// position, and a skipped record is not scanned; the scan reads one
// table entry per cycle through the single read port of the group table.
// Reset clears the entry count; table contents need no clearing.
// A waiting result does not block the next record; only the commit of the
// following result waits for the output register to free up.
// ----------------------------------------------------------------------------
module interval_key_grouper
	import ikg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               has_image,
	input  wire logic [7:0]         filter_code,
	input  wire logic [7:0]         detector_code,
	input  wire logic [3:0]         frame_type,
	input  wire logic [TimeW-1:0]   time_begin,
	input  wire logic [TimeW-1:0]   time_end,
	input  wire logic               last_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [OutIdxW-1:0]      group_index,
	output logic                    new_group,
	output logic                    skipped,
	output logic                    table_overflow,
	output logic [OutCntW-1:0]      groups_used,
	output logic                    batch_end
);

	ikg_cmd_t cmd;
	ikg_sts_t sts;

	ikg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ikg_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.has_image      (has_image),
		.filter_code    (filter_code),
		.detector_code  (detector_code),
		.frame_type     (frame_type),
		.time_begin     (time_begin),
		.time_end       (time_end),
		.last_item      (last_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.group_index    (group_index),
		.new_group      (new_group),
		.skipped        (skipped),
		.table_overflow (table_overflow),
		.groups_used    (groups_used),
		.batch_end      (batch_end)
	);

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.slot_free)
		else $error("result committed while output register busy");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transfer taken during a scan");

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !(new_group && (skipped || table_overflow)))
		else $error("new group flagged together with skip or overflow");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");

endmodule
`default_nettype wire
